[rtl/rhs_pkg.sv]
// Shared constants and types of the RGB half-scale downsampler.
`default_nettype none
package rhs_pkg;

  localparam int PIX_W      = 8;    // one color channel
  localparam int PSUM_W     = PIX_W + 1;  // sum of two channel values
  localparam int BSUM_W     = PIX_W + 2;  // sum of four channel values
  localparam int OUT_POS_W  = 10;   // output column and row fields
  localparam int CFG_DIM_W  = 12;   // frame_width and frame_height registers

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [PSUM_W-1:0] r;
    logic [PSUM_W-1:0] g;
    logic [PSUM_W-1:0] b;
  } pair_sum_t;

endpackage
`default_nettype wire

[rtl/rhs_ifs.sv]
// Stream interfaces: source pixel channel and downsampled result channel.
`default_nettype none
interface rhs_pix_if import rhs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rhs_res_if import rhs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     red_out;
  logic [PIX_W-1:0]     green_out;
  logic [PIX_W-1:0]     blue_out;
  logic [OUT_POS_W-1:0] out_column;
  logic [OUT_POS_W-1:0] out_row;
  logic                 frame_last;

  modport source (output valid, red_out, green_out, blue_out, out_column, out_row,
                  frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_column, out_row,
                  frame_last, output ready);
endinterface
`default_nettype wire

[rtl/rhs_apb_regs.sv]
// APB register block: frame size registers, clamping and frame restart pulse.
`default_nettype none
module rhs_apb_regs import rhs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1),
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [WDIM_W-1:0]     frame_w,
  output logic      [HDIM_W-1:0]     frame_h,
  output logic                       restart
);

  localparam int WX_W = (WDIM_W > CFG_DIM_W) ? WDIM_W : CFG_DIM_W;
  localparam int HX_W = (HDIM_W > CFG_DIM_W) ? HDIM_W : CFG_DIM_W;

  logic [CFG_DIM_W-1:0] frame_width_r;
  logic [CFG_DIM_W-1:0] frame_height_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [WX_W-1:0]      w_ext;
  logic [HX_W-1:0]      h_ext;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign restart = wr_en;   // every register here restarts the frame

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // clamp to 2..MAX
  always_comb begin
    w_ext = WX_W'(frame_width_r);
    h_ext = HX_W'(frame_height_r);
    if (w_ext < WX_W'(2))               frame_w = WDIM_W'(2);
    else if (w_ext > WX_W'(MAX_WIDTH))  frame_w = WDIM_W'(MAX_WIDTH);
    else                                frame_w = WDIM_W'(w_ext);
    if (h_ext < HX_W'(2))               frame_h = HDIM_W'(2);
    else if (h_ext > HX_W'(MAX_HEIGHT)) frame_h = HDIM_W'(MAX_HEIGHT);
    else                                frame_h = HDIM_W'(h_ext);
  end

endmodule
`default_nettype wire

[rtl/rgb_half_scale_downsampler.sv]
// Top level: 2x2 box-filter downsampler with a line buffer of top-row pair sums.
// Throughput: one source pixel per clock while the result side is ready; no row-end bubbles.
// Result path: accepting a block's bottom-right pixel registers its bottom pair sum and
//   the line buffer read; the two pair sums are then added and held in the output reg.
// Reset (rst_n, synchronous): position counters to column 0 / row 0, frame size
//   to 640x480, pipeline emptied. The line buffer is not cleared: every entry is
//   written on an even row before the odd row below reads it.
`default_nettype none
module rgb_half_scale_downsampler import rhs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  rhs_pix_if.sink                    in_px,
  rhs_res_if.source                  out_px
);

  localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // ---------------------------------------------------------------- config
  logic [WDIM_W-1:0] frame_w;
  logic [HDIM_W-1:0] frame_h;
  logic              restart;

  rhs_apb_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .frame_w (frame_w),
    .frame_h (frame_h),
    .restart (restart)
  );

  // ---------------------------------------------------------------- handshake
  // Pipeline: stage 0 = accept beat, write or read line buffer;
  // stage 1 = bottom pair sum plus registered top pair sum; stage 2 = output reg.
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_acc;

  assign s1_adv       = s1_valid_r & (~out_valid_r | out_px.ready);
  assign in_px.ready  = ~s1_valid_r | s1_adv;
  assign in_acc       = in_px.valid & in_px.ready;

  // ---------------------------------------------------------------- position
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [WDIM_W-1:0] col_plus;
  logic [HDIM_W-1:0] row_plus;
  logic              col_odd, row_odd;

  assign col_odd  = col_r[0];
  assign row_odd  = row_r[0];
  assign col_plus = WDIM_W'(col_r) + WDIM_W'(1);
  assign row_plus = HDIM_W'(row_r) + HDIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_plus == frame_w) begin
        col_nxt = '0;
        row_nxt = (row_plus == frame_h) ? '0 : ROW_W'(row_plus);
      end else begin
        col_nxt = COL_W'(col_plus);
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  rgb_t      pix_in;
  rgb_t      left_r;
  pair_sum_t pair_sum;
  logic [IDX_W-1:0] line_idx;
  logic      mem_we, mem_re;
  logic      blk_last;

  assign pix_in = '{r: in_px.red_in, g: in_px.green_in, b: in_px.blue_in};

  assign pair_sum.r = PSUM_W'(left_r.r) + PSUM_W'(pix_in.r);
  assign pair_sum.g = PSUM_W'(left_r.g) + PSUM_W'(pix_in.g);
  assign pair_sum.b = PSUM_W'(left_r.b) + PSUM_W'(pix_in.b);

  assign line_idx = IDX_W'(col_r >> 1);
  assign mem_we   = in_acc & col_odd & ~row_odd;   // top row: store pair sum
  assign mem_re   = in_acc & col_odd &  row_odd;   // bottom row: fetch it

  assign blk_last = (WDIM_W'(col_r >> 1) == (frame_w >> 1) - WDIM_W'(1)) &&
                    (HDIM_W'(row_r >> 1) == (frame_h >> 1) - HDIM_W'(1));

  // line buffer of top-row pair sums; read data registered
  pair_sum_t line_mem [LINE_DEPTH];
  pair_sum_t top_r;

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[line_idx] <= pair_sum;
    if (mem_re) top_r <= line_mem[line_idx];
  end

  // ---------------------------------------------------------------- stage 1
  pair_sum_t            s1_bot_r;
  logic [OUT_POS_W-1:0] s1_col_r, s1_row_r;
  logic                 s1_last_r;

  always_ff @(posedge clk) begin
    if (in_acc && !col_odd) left_r <= pix_in;
    if (mem_re) begin
      s1_bot_r  <= pair_sum;
      s1_col_r  <= OUT_POS_W'(col_r >> 1);
      s1_row_r  <= OUT_POS_W'(row_r >> 1);
      s1_last_r <= blk_last;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [BSUM_W-1:0]    sum_r4, sum_g4, sum_b4;
  logic [PIX_W-1:0]     red_r, green_r, blue_r;
  logic [OUT_POS_W-1:0] ocol_r, orow_r;
  logic                 olast_r;

  assign sum_r4 = BSUM_W'(s1_bot_r.r) + BSUM_W'(top_r.r);
  assign sum_g4 = BSUM_W'(s1_bot_r.g) + BSUM_W'(top_r.g);
  assign sum_b4 = BSUM_W'(s1_bot_r.b) + BSUM_W'(top_r.b);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      red_r   <= sum_r4[BSUM_W-1:2];
      green_r <= sum_g4[BSUM_W-1:2];
      blue_r  <= sum_b4[BSUM_W-1:2];
      ocol_r  <= s1_col_r;
      orow_r  <= s1_row_r;
      olast_r <= s1_last_r;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv)      s1_valid_nxt = 1'b0;
    if (mem_re)      s1_valid_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_px.ready) out_valid_nxt = 1'b0;
    if (s1_adv)                      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_px.valid      = out_valid_r;
  assign out_px.red_out    = red_r;
  assign out_px.green_out  = green_r;
  assign out_px.blue_out   = blue_r;
  assign out_px.out_column = ocol_r;
  assign out_px.out_row    = orow_r;
  assign out_px.frame_last = olast_r;

  // ---------------------------------------------------------------- checks
  // position never leaves the frame
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    WDIM_W'(col_r) < frame_w && HDIM_W'(row_r) < frame_h)
    else $error("column or row counter outside frame");

  // line buffer is never written and read in the same cycle
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("line buffer write and read collide");

  // a stalled stage-1 block stays put, and no new pixel is taken behind it
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_px.ready ##1 s1_valid_r)
    else $error("stage 1 block lost under stall");

  // a rising result valid comes from a stage-1 block that advanced in the cycle before
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result beat without stage 1 source");

  // a pair from an odd column of an odd row always lands in stage 1
  a_s1_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> s1_valid_r)
    else $error("bottom-row pair not captured");

endmodule
`default_nettype wire

[dv/rgb_half_scale_downsampler_test.sv]
// Testbench for the RGB half-scale downsampler: directed table, then random frames.
module rgb_half_scale_downsampler_test import rhs_pkg::*;;

  // Watchdog: cycles in a row with no beat on either channel before the run is declared hung.
  // Longest correct quiet stretch is the receiver hold-off plus a sender gap plus a
  // register write and drain, and QUIET_LIMIT leaves a wide margin over it.
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;    // pipeline is 2 deep; extra margin
  localparam int unsigned SETTLE_CYCLES  = 8;    // quiet time at the end of the run
  localparam int unsigned RX_HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int unsigned RANDOM_PIXELS  = 730;
  localparam int unsigned PHASE_CAP      = 120;  // most pixels per random phase

  // One downsampled pixel as it leaves the block.
  typedef struct packed {
    logic [PIX_W-1:0]     r;
    logic [PIX_W-1:0]     g;
    logic [PIX_W-1:0]     b;
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    logic                 last;
  } block_avg_t;

  // Directed table: a row is either a register write or a source pixel, the latter
  // optionally carrying a hand-computed result.
  typedef enum {STEP_CFG, STEP_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CFG_DIM_W-1:0] reg_val;
    rgb_t                 px;
    bit                   typed;
    block_avg_t           avg;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rhs_pix_if pix ();
  rhs_res_if res ();

  rgb_half_scale_downsampler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_px  (pix),
    .out_px (res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers, raster position, held left pixel and the
  // line of top-row pair sums.
  // ---------------------------------------------------------------------------
  int unsigned cfg_width  = FRAME_WIDTH_RST;
  int unsigned cfg_height = FRAME_HEIGHT_RST;
  int unsigned pos_col    = 0;
  int unsigned pos_row    = 0;
  rgb_t        left_px    = '0;
  pair_sum_t   top_sums [MAX_WIDTH_DEF/2];

  block_avg_t  avg_q [$];        // expected result beats, oldest first
  step_t       directed_steps [$];

  int unsigned mismatches   = 0;
  int unsigned pixels_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned holdoffs     = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_req     = 1'b0;  // asks the result sink for one long hold-off

  // Out-of-range frame sizes act as the nearest legal size.
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the predictor by one source pixel; returns 1 when a block completes.
  function automatic bit downsample_pixel(input rgb_t px, output block_avg_t avg);
    int unsigned       w, h, idx;
    pair_sum_t         bottom, top;
    logic [BSUM_W-1:0] sr, sg, sb;
    bit                produced;
    w        = clamp_dim(cfg_width, MAX_WIDTH_DEF);
    h        = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
    produced = 1'b0;
    avg      = '0;
    if (pos_col % 2 == 0) begin
      left_px = px;
    end else begin
      bottom.r = PSUM_W'(left_px.r) + PSUM_W'(px.r);
      bottom.g = PSUM_W'(left_px.g) + PSUM_W'(px.g);
      bottom.b = PSUM_W'(left_px.b) + PSUM_W'(px.b);
      idx      = pos_col / 2;
      if (pos_row % 2 == 0) begin
        top_sums[idx] = bottom;   // top half of the block, parked for the next row
      end else begin
        top      = top_sums[idx];
        sr       = BSUM_W'(bottom.r) + BSUM_W'(top.r);
        sg       = BSUM_W'(bottom.g) + BSUM_W'(top.g);
        sb       = BSUM_W'(bottom.b) + BSUM_W'(top.b);
        avg.r    = sr[BSUM_W-1:2];
        avg.g    = sg[BSUM_W-1:2];
        avg.b    = sb[BSUM_W-1:2];
        avg.col  = OUT_POS_W'(pos_col / 2);
        avg.row  = OUT_POS_W'(pos_row / 2);
        avg.last = (pos_col / 2 == w / 2 - 1) && (pos_row / 2 == h / 2 - 1);
        produced = 1'b1;
      end
    end
    // raster advance; trailing odd column/row simply falls through here
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
    return produced;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Channel value biased toward the rails so the sums hit their extremes often.
  function automatic logic [PIX_W-1:0] pick_chan();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t px;
    px.r = pick_chan();
    px.g = pick_chan();
    px.b = pick_chan();
    return px;
  endfunction

  // Register size: mostly small frames, some mid, some below or above the legal range.
  function automatic logic [CFG_DIM_W-1:0] pick_dim(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return CFG_DIM_W'($urandom_range(0, 1));
    if (r < 14) return CFG_DIM_W'($urandom_range(hi + 1, (1 << CFG_DIM_W) - 1));
    if (r < 30) return CFG_DIM_W'($urandom_range(9, 64));
    return CFG_DIM_W'($urandom_range(2, 8));
  endfunction

  function automatic void add_cfg(logic [REG_IDX_W-1:0] idx, logic [CFG_DIM_W-1:0] val);
    step_t s;
    s = '{kind: STEP_CFG, reg_idx: idx, reg_val: val, px: '0, typed: 1'b0, avg: '0};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_px(rgb_t px, bit typed = 1'b0, block_avg_t avg = '0);
    step_t s;
    s = '{kind: STEP_PIXEL, reg_idx: '0, reg_val: '0, px: px, typed: typed, avg: avg};
    directed_steps.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Config port. Setup phase, then access until pready; the bus then idles so
  // back-to-back transfers never assign psel twice in one step.
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned want);
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    check_field(idx == REG_FRAME_WIDTH ? "frame_width" : "frame_height", want, rd);
  endtask

  // Stop offering pixels and let every outstanding beat (and any pixel still in
  // the pipe that makes no result) drain.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    do @(posedge clk); while (avg_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A write restarts the frame, so the shadow position goes back to the origin.
  task automatic write_cfg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DIM_W-1:0] val);
    logic [APB_DATA_W-1:0] rd;
    wait_idle();
    apb_xfer(1'b1, idx, APB_DATA_W'(val), rd);
    if (idx == REG_FRAME_WIDTH) cfg_width = val;
    else cfg_height = val;
    pos_col = 0;
    pos_row = 0;
    cfg_writes++;
    check_reg(idx, val);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel source. Holds the beat until accepted, then runs the predictor. A
  // directed row may supply its own expected beat in place of the predicted one.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input rgb_t px, input bit typed = 1'b0,
                            input block_avg_t typed_avg = '0);
    block_avg_t avg;
    bit         produced;
    pix.valid    <= 1'b1;
    pix.red_in   <= px.r;
    pix.green_in <= px.g;
    pix.blue_in  <= px.b;
    do @(posedge clk); while (!pix.ready);
    pixels_sent++;
    produced = downsample_pixel(px, avg);
    if (typed) avg_q.push_back(typed_avg);
    else if (produced) avg_q.push_back(avg);
  endtask

  // valid drops only when a real gap follows, so back-to-back beats keep it high
  task automatic idle_sender(input int unsigned n);
    if (n > 0) begin
      pix.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: bursts of ready, random stalls, and one long hold-off on request.
  // A request cuts the current burst short so the hold-off starts right away.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned burst, gap;
    res.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      // now and then a long stretch with no stall at all
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      res.ready <= 1'b1;
      @(posedge clk);
      for (int unsigned k = 1; k < burst && !hold_req; k++) @(posedge clk);
      if (hold_req) begin
        gap      = RX_HOLD_CYCLES;
        hold_req = 1'b0;
        holdoffs++;
      end else begin
        gap = pick_gap();
      end
      if (gap != 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Scoreboard: each result beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    block_avg_t want;
    if (rst_n && res.valid && res.ready) begin
      results_seen++;
      if (avg_q.size() == 0) begin
        $error("result beat with nothing expected: column %0d row %0d",
               res.out_column, res.out_row);
        mismatches++;
      end else begin
        want = avg_q.pop_front();
        check_field("red_out",    want.r,    res.red_out);
        check_field("green_out",  want.g,    res.green_out);
        check_field("blue_out",   want.b,    res.blue_out);
        check_field("out_column", want.col,  res.out_column);
        check_field("out_row",    want.row,  res.out_row);
        check_field("frame_last", want.last, res.frame_last);
      end
    end
  end

  // Watchdog: any beat on either channel counts as progress.
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d beats still expected",
               quiet_cycles, avg_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w, h, n, phase, random_sent;
    bit          steady, paused_once;

    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    pix.valid    <= 1'b0;
    pix.red_in   <= '0;
    pix.green_in <= '0;
    pix.blue_in  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the size registers
    check_reg(REG_FRAME_WIDTH, FRAME_WIDTH_RST);
    check_reg(REG_FRAME_HEIGHT, FRAME_HEIGHT_RST);

    // --- directed table ---
    // 0 and 1 clamp to 2: every 4 pixels make one full 2x2 frame
    add_cfg(REG_FRAME_WIDTH, 12'd0);
    add_cfg(REG_FRAME_HEIGHT, 12'd1);
    // all-white block: top of range, also the last pixel of the frame
    add_px(24'hFFFFFF); add_px(24'hFFFFFF); add_px(24'hFFFFFF);
    add_px(24'hFFFFFF, 1'b1, '{8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1'b1});
    // all-black block, after the frame wrapped back to the origin
    add_px(24'h000000); add_px(24'h000000); add_px(24'h000000);
    add_px(24'h000000, 1'b1, '{8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b1});
    // truncation: red 3/4 -> 0, green 1019/4 -> 254, blue 128/4 -> 32
    add_px(24'h01FF80); add_px(24'h01FF00); add_px(24'h01FF00);
    add_px(24'h00FE00, 1'b1, '{8'd0, 8'd254, 8'd32, 10'd0, 10'd0, 1'b1});
    // 3x3: trailing odd column and trailing odd row make nothing
    add_cfg(REG_FRAME_WIDTH, 12'd3);
    add_cfg(REG_FRAME_HEIGHT, 12'd3);
    add_px(24'h102030); add_px(24'hF0E0D0); add_px(24'h55AA55);
    add_px(24'h7F8081); add_px(24'h010203); add_px(24'hAA55AA);
    add_px(24'h336699); add_px(24'hC0FFEE); add_px(24'h0F0F0F);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        write_cfg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_pixel(directed_steps[i].px, directed_steps[i].typed, directed_steps[i].avg);
        idle_sender(pick_gap());
      end
    end

    // --- random frames ---
    // each phase may set a new size and sends whole frames with random content; some
    // phases end mid-frame, and the next write restarts the raster anyway
    random_sent = 0;
    phase       = 0;
    paused_once = 1'b0;
    while (random_sent < RANDOM_PIXELS) begin
      if (phase == 2) begin
        // small frames, dense results, steady source: the long hold-off on the
        // result side backs the block up until it stalls its input
        write_cfg(REG_FRAME_WIDTH, 12'd4);
        write_cfg(REG_FRAME_HEIGHT, 12'd4);
        steady   = 1'b1;
        n        = 120;
        hold_req = 1'b1;
      end else begin
        if ($urandom_range(0, 3) != 0) write_cfg(REG_FRAME_WIDTH, pick_dim(MAX_WIDTH_DEF));
        if ($urandom_range(0, 3) != 0) write_cfg(REG_FRAME_HEIGHT, pick_dim(MAX_HEIGHT_DEF));
        steady = ($urandom_range(0, 3) == 0);
        w      = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h      = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        n      = w * h * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w * h);  // partial frame
        if (n > PHASE_CAP) n = $urandom_range(50, PHASE_CAP);
      end
      if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;
      for (int unsigned i = 0; i < n; i++) begin
        send_pixel(rand_pixel());
        random_sent++;
        if ((!paused_once && phase == 1 && i == n / 2) || $urandom_range(0, 99) == 0) begin
          // source holds back until the block has handed over every result
          paused_once = 1'b1;
          pix.valid <= 1'b0;
          do @(posedge clk); while (avg_q.size() != 0);
        end else if (!steady) begin
          idle_sender(pick_gap());
        end
      end
      phase++;
    end

    // --- drain and verdict ---
    pix.valid <= 1'b0;
    while (avg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered: %0d pixels, %0d result beats, %0d register writes, %0d long hold-offs",
             pixels_sent, results_seen, cfg_writes, holdoffs);
    $display("sizes from clamped 2x2 to clamped oversize, odd trailing rows and columns");
    if (mismatches == 0 && avg_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
